[sv/sssd_pkg.sv]
package sssd_pkg;

  localparam int DIGITS_DEF = 6;

  localparam int VALUE_W    = 20;
  localparam int DOT_W      = 6;
  localparam int DUR_W      = 16;
  localparam int TPS_W      = 16;
  localparam int LIMIT_W    = DUR_W + TPS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int CONV_CNT_W = $clog2(VALUE_W + 1);
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [DUR_W-1:0]   DUR_RESET   = 16'd1;
  localparam logic [TPS_W-1:0]   TPS_RESET   = 16'd1000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1000;

  // high byte of the word: all selects off (active low)
  localparam logic [7:0] SEL_ALL = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISPLAY_VALUE = 3'd0,
    CFG_DOT_MASK      = 3'd1,
    CFG_DURATION      = 3'd2,
    CFG_TICKS_PER_SEC = 3'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STOP_NONE     = 2'd0,
    STOP_DURATION = 2'd1,
    STOP_QUIT     = 2'd2
  } stop_t;

  typedef struct packed {
    logic clear;   // zero the conversion digit
    logic shift;   // one double-dabble step
    logic load;    // scan digit takes neighbor's converted digit
    logic rotate;  // scan digit takes neighbor's scan digit
  } cell_ctrl_t;

  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h27;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

[sv/sssd_cell.sv]
module sssd_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sssd_pkg::cell_ctrl_t ctrl,
  input  logic                 carry_in,
  output logic                 carry_out,
  input  logic [3:0]           conv_in,
  input  logic [3:0]           scan_in,
  output logic [3:0]           conv_digit,
  output logic [3:0]           scan_digit
);
  import sssd_pkg::*;

  logic [3:0] conv_r, conv_nxt;
  logic [3:0] scan_r, scan_nxt;
  logic [3:0] adj;

  // add 3 when the digit would overflow past 9 after doubling
  always_comb begin
    adj       = (conv_r >= 4'd5) ? conv_r + 4'd3 : conv_r;
    carry_out = adj[3];
    if (ctrl.clear) begin
      conv_nxt = 4'd0;
    end else if (ctrl.shift) begin
      conv_nxt = {adj[2:0], carry_in};
    end else begin
      conv_nxt = conv_r;
    end
    if (ctrl.load) begin
      scan_nxt = conv_in;
    end else if (ctrl.rotate) begin
      scan_nxt = scan_in;
    end else begin
      scan_nxt = scan_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r <= 4'd0;
    end else begin
      conv_r <= conv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
  end

  assign conv_digit = conv_r;
  assign scan_digit = scan_r;

endmodule

[sv/seven_segment_scan_driver.sv]
// a scan tick's word is registered in the output register and shows there the cycle after the tick is accepted
// throughput: one tick per cycle unless stalled by output back-pressure, a config update or a
//   pending closing word; the tick that ends a run holds input off until the closing blank word is registered
// a display_value write runs a bit-serial conversion through the digit cells, stalling input and
//   config until it is done; duration and rate writes stall both while the limit updates
// reset (synchronous, active low): idle, registers at 0 / 0 / 1 / 1000, digits converted to 0
module seven_segment_scan_driver #(
  parameter int DIGIT_COUNT = sssd_pkg::DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sssd_pkg::IN_DATA_W-1:0]   in_tdata,   // [0] start_req, [1] quit_key
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sssd_pkg::OUT_DATA_W-1:0]  out_tdata,  // [15:0] segment_word
  output logic                             out_tlast,
  output logic [1:0]                       out_tuser,  // [1:0] stop_reason
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sssd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sssd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sssd_pkg::*;

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGIT_COUNT - 1);

  // configuration
  logic [DOT_W-1:0]      dot_mask_r;
  logic [DUR_W-1:0]      dur_r;
  logic [TPS_W-1:0]      tps_r;
  logic [LIMIT_W-1:0]    limit_r;
  logic                  prod_wait_r;
  logic [VALUE_W-1:0]    sreg_r;
  logic [CONV_CNT_W-1:0] conv_cnt_r;
  logic                  cfg_fire;
  logic                  busy;
  cfg_idx_t              cfg_sel;

  // scan state
  logic                  running_r, running_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [LIMIT_W-1:0]    count_r, count_nxt;
  logic [LIMIT_W-1:0]    run_limit_r, run_limit_nxt;

  // output stage
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_word_r, out_word_nxt;
  logic                  out_last_r, out_last_nxt;
  stop_t                 out_reason_r, out_reason_nxt;
  logic                  pend_r, pend_nxt;
  stop_t                 pend_reason_r, pend_reason_nxt;

  logic                  fire_in, start, quit, begin_run, tick, dur_end, out_free;
  logic [IDX_W-1:0]      d;
  logic [2:0]            d8;
  logic [3:0]            cur_digit;
  logic                  dot;
  logic [OUT_DATA_W-1:0] word;

  cell_ctrl_t            cell_ctrl;
  logic [3:0]            conv_d [DIGIT_COUNT];
  logic [3:0]            scan_d [DIGIT_COUNT];
  logic                  carry  [DIGIT_COUNT];

  assign cfg_sel   = cfg_idx_t'(cfg_index);
  assign busy      = (conv_cnt_r != '0) || prod_wait_r;
  assign cfg_ready = !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_mask_r  <= '0;
      dur_r       <= DUR_RESET;
      tps_r       <= TPS_RESET;
      limit_r     <= LIMIT_RESET;
      prod_wait_r <= 1'b0;
      conv_cnt_r  <= '0;
    end else begin
      limit_r     <= LIMIT_W'(dur_r) * LIMIT_W'(tps_r);
      prod_wait_r <= 1'b0;
      if (conv_cnt_r != '0) begin
        conv_cnt_r <= conv_cnt_r - 1'b1;
      end
      if (cfg_fire) begin
        unique case (cfg_sel)
          CFG_DISPLAY_VALUE: conv_cnt_r <= CONV_CNT_W'(VALUE_W);
          CFG_DOT_MASK:      dot_mask_r <= cfg_data[DOT_W-1:0];
          CFG_DURATION: begin
            dur_r       <= cfg_data[DUR_W-1:0];
            prod_wait_r <= 1'b1;
          end
          CFG_TICKS_PER_SEC: begin
            tps_r       <= cfg_data[TPS_W-1:0];
            prod_wait_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // value shifts out msb first into the least significant digit cell
  always_ff @(posedge clk) begin
    if (cfg_fire && cfg_sel == CFG_DISPLAY_VALUE) begin
      sreg_r <= cfg_data[VALUE_W-1:0];
    end else if (conv_cnt_r != '0) begin
      sreg_r <= {sreg_r[VALUE_W-2:0], 1'b0};
    end
  end

  // scan tick
  assign fire_in   = in_tvalid && in_tready;
  assign start     = in_tdata[0];
  assign quit      = in_tdata[1];
  assign begin_run = !running_r && start;
  assign tick      = fire_in && (running_r || start);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !busy && !pend_r && out_free;

  always_comb begin
    cell_ctrl.clear  = cfg_fire && cfg_sel == CFG_DISPLAY_VALUE;
    cell_ctrl.shift  = conv_cnt_r != '0;
    cell_ctrl.load   = tick && begin_run;
    cell_ctrl.rotate = tick && !begin_run;
  end

  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
    localparam int NB = (i + 1) % DIGIT_COUNT;
    logic cin;
    if (i == DIGIT_COUNT - 1) begin : g_tail
      assign cin = sreg_r[VALUE_W-1];
    end else begin : g_mid
      assign cin = carry[i+1];
    end
    sssd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .carry_in   (cin),
      .carry_out  (carry[i]),
      .conv_in    (conv_d[NB]),
      .scan_in    (scan_d[NB]),
      .conv_digit (conv_d[i]),
      .scan_digit (scan_d[i])
    );
  end

  always_comb begin
    d         = begin_run ? '0 : idx_r;
    d8        = 3'(d);
    cur_digit = begin_run ? conv_d[0] : scan_d[0];
    dot       = (d8 < 3'(DOT_W)) && dot_mask_r[d8];
    word      = {SEL_ALL & ~(8'd1 << d8), dot, seg_of(cur_digit)};
    // limit is frozen for the whole run
    dur_end   = begin_run ? (limit_r == '0) : (count_r >= run_limit_r);
  end

  always_comb begin
    running_nxt     = running_r;
    idx_nxt         = idx_r;
    count_nxt       = count_r;
    run_limit_nxt   = run_limit_r;
    out_valid_nxt   = out_valid_r;
    out_word_nxt    = out_word_r;
    out_last_nxt    = out_last_r;
    out_reason_nxt  = out_reason_r;
    pend_nxt        = pend_r;
    pend_reason_nxt = pend_reason_r;
    if (tick) begin
      idx_nxt        = (d == IDX_LAST) ? '0 : d + 1'b1;
      count_nxt      = begin_run ? LIMIT_W'(1) : count_r + 1'b1;
      if (begin_run) begin
        run_limit_nxt = limit_r;
      end
      out_valid_nxt  = 1'b1;
      out_word_nxt   = word;
      out_last_nxt   = 1'b0;
      out_reason_nxt = STOP_NONE;
      running_nxt    = !(dur_end || quit);
      if (dur_end || quit) begin
        pend_nxt        = 1'b1;
        pend_reason_nxt = dur_end ? STOP_DURATION : STOP_QUIT;
      end
    end else if (pend_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_word_nxt   = '0;
      out_last_nxt   = 1'b1;
      out_reason_nxt = pend_reason_r;
      pend_nxt       = 1'b0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      idx_r       <= '0;
      count_r     <= '0;
      run_limit_r <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      running_r   <= running_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      run_limit_r <= run_limit_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r    <= out_word_nxt;
    out_last_r    <= out_last_nxt;
    out_reason_r  <= out_reason_nxt;
    pend_reason_r <= pend_reason_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_reason_r;

`ifndef SYNTHESIS
  a_pend_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !in_tready)
    else $error("input taken while closing word pending");

  a_conv_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (conv_cnt_r != '0) |-> (!in_tready && !cfg_ready))
    else $error("transaction taken during digit conversion");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && (dur_end || quit)) |=> (pend_r && !running_r))
    else $error("run end did not queue closing word");

  a_last_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == '0 && out_tuser != STOP_NONE))
    else $error("closing word not blank or missing reason");

  a_one_select: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> ($countones(out_tdata[15:8]) == 7 && out_tuser == STOP_NONE))
    else $error("digit word must select exactly one digit");
`endif

endmodule

[tb/sv/tb_seven_segment_scan_driver.sv]
`timescale 1ns / 1ps

module tb_seven_segment_scan_driver;
  import sssd_pkg::*;

  localparam int NDIG        = DIGITS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_ITEMS  = 1200;
  localparam int HOLD_LONG   = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  localparam logic [6:0] SEG_PATTERN [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h27, 7'h7F, 7'h6F
  };

  typedef struct packed {
    logic [15:0] word;
    logic        last;
    stop_t       reason;
  } disp_word_t;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic                 start;
    logic                 quit;
    logic                 pinned;
    logic [1:0]           n;
    disp_word_t           a;
    disp_word_t           b;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic [1:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  seven_segment_scan_driver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predicted display state
  logic [VALUE_W-1:0] disp_value = '0;
  logic [DOT_W-1:0]   dot_bits   = '0;
  logic [DUR_W-1:0]   dur_sec    = DUR_RESET;
  logic [TPS_W-1:0]   tick_rate  = TPS_RESET;
  logic               run_on     = 1'b0;
  logic [2:0]         scan_pos   = '0;
  logic [31:0]        ticks_done = '0;
  logic [31:0]        ticks_max  = '0;
  logic [3:0]         digit_mem [NDIG];

  disp_word_t exp_words[$];
  stim_row_t  stim_tab[$];

  int err_count   = 0;
  int scan_items  = 0;
  int cycle_cnt   = 0;
  int tx_gap_max  = 16;
  int rx_gap_max  = 16;
  int rx_hold_cycles = 0;

  // typed expectation for the next directed transaction, replaces the prediction
  logic       pin_on = 1'b0;
  int         pin_cnt = 0;
  disp_word_t pin_a, pin_b;

  function automatic int scan_tick(input logic start, input logic quit,
                                   output disp_word_t w0, output disp_word_t w1);
    logic [VALUE_W-1:0] v;
    int i;
    w0 = '0;
    w1 = '0;
    if (!run_on) begin
      if (!start) return 0;
      v = disp_value;
      for (i = NDIG - 1; i >= 0; i--) begin
        digit_mem[i] = 4'(v % 10);
        v = v / 10;
      end
      ticks_max  = dur_sec * tick_rate;
      ticks_done = '0;
      scan_pos   = '0;
      run_on     = 1'b1;
    end
    w0.word   = {~(8'd1 << scan_pos), dot_bits[scan_pos], SEG_PATTERN[digit_mem[scan_pos]]};
    w0.last   = 1'b0;
    w0.reason = STOP_NONE;
    scan_pos   = (scan_pos == NDIG - 1) ? 3'd0 : scan_pos + 3'd1;
    ticks_done = ticks_done + 1;
    if (ticks_done > ticks_max) begin
      w1.last   = 1'b1;
      w1.reason = STOP_DURATION;
      run_on    = 1'b0;
      return 2;
    end
    if (quit) begin
      w1.last   = 1'b1;
      w1.reason = STOP_QUIT;
      run_on    = 1'b0;
      return 2;
    end
    return 1;
  endfunction

  function automatic int draw_gap(input int max);
    return (max == 0) ? 0 : $urandom_range(0, max);
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 2;
      default: return 16;
    endcase
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    stim_tab.push_back(r);
  endfunction

  function automatic void add_tick(input logic start, input logic quit, input logic pinned,
                                   input logic [1:0] n, input disp_word_t a,
                                   input disp_word_t b);
    stim_row_t r;
    r = '0;
    r.kind   = ROW_TICK;
    r.start  = start;
    r.quit   = quit;
    r.pinned = pinned;
    r.n      = n;
    r.a      = a;
    r.b      = b;
    stim_tab.push_back(r);
  endfunction

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_seven_segment_scan_driver failed");
      $finish;
    end
  end

  // monitor: config shadow, prediction and comparison
  always @(posedge clk) begin
    int n;
    disp_word_t r0, r1, got, want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DISPLAY_VALUE: disp_value = cfg_data[VALUE_W-1:0];
          CFG_DOT_MASK:      dot_bits   = cfg_data[DOT_W-1:0];
          CFG_DURATION:      dur_sec    = cfg_data[DUR_W-1:0];
          CFG_TICKS_PER_SEC: tick_rate  = cfg_data[TPS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        n = scan_tick(in_tdata[0], in_tdata[1], r0, r1);
        if (pin_on) begin
          n      = pin_cnt;
          r0     = pin_a;
          r1     = pin_b;
          pin_on = 1'b0;
        end
        if (n > 0) begin
          exp_words.push_back(r0);
          scan_items++;
        end
        if (n > 1) exp_words.push_back(r1);
      end
      if (out_tvalid && out_tready) begin
        got.word   = out_tdata;
        got.last   = out_tlast;
        got.reason = stop_t'(out_tuser);
        if (exp_words.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: word %h last %b reason %0d",
                     got.word, got.last, got.reason);
        end else begin
          want = exp_words.pop_front();
          if (got != want) begin
            err_count++;
            if (err_count <= 10)
              $display({"mismatch: expected word %h last %b reason %0d, ",
                        "got word %h last %b reason %0d"},
                       want.word, want.last, want.reason, got.word, got.last, got.reason);
          end
        end
      end
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    int n;
    out_tready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = draw_gap(rx_gap_max);
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (exp_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic start, input logic quit);
    int gap;
    gap = draw_gap(tx_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-2){1'b0}}, quit, start};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    int base, phase, run_len;
    logic [CFG_DATA_W-1:0] val;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // directed part
    add_tick(1'b0, 1'b0, 1'b1, 2'd0, '0, '0);  // idle, no start
    add_tick(1'b1, 1'b1, 1'b1, 2'd2, '{16'hFE3F, 1'b0, STOP_NONE}, '{16'h0000, 1'b1, STOP_QUIT});
    add_cfg(CFG_DISPLAY_VALUE, 20'd999999);
    add_cfg(CFG_DOT_MASK, 20'd63);
    add_cfg(CFG_DURATION, 20'd0);
    add_cfg(CFG_TICKS_PER_SEC, 20'd65535);
    // zero duration: one digit word then the end
    add_tick(1'b1, 1'b0, 1'b1, 2'd2, '{16'hFEEF, 1'b0, STOP_NONE},
             '{16'h0000, 1'b1, STOP_DURATION});
    add_cfg(CFG_DURATION, 20'd1);
    add_cfg(CFG_TICKS_PER_SEC, 20'd1);
    add_tick(1'b1, 1'b0, 1'b1, 2'd1, '{16'hFEEF, 1'b0, STOP_NONE}, '0);
    // duration and quit together, duration wins
    add_tick(1'b0, 1'b1, 1'b1, 2'd2, '{16'hFDEF, 1'b0, STOP_NONE},
             '{16'h0000, 1'b1, STOP_DURATION});
    add_cfg(CFG_DISPLAY_VALUE, 20'd123456);
    add_cfg(CFG_DOT_MASK, 20'd0);
    add_cfg(CFG_DURATION, 20'd65535);
    add_cfg(CFG_TICKS_PER_SEC, 20'd65535);
    add_tick(1'b1, 1'b0, 1'b0, 2'd0, '0, '0);
    add_tick(1'b1, 1'b0, 1'b0, 2'd0, '0, '0);  // start while running
    repeat (6) add_tick(1'b0, 1'b0, 1'b0, 2'd0, '0, '0);
    // writes during a run: live dot mask, digits stay latched
    add_cfg(CFG_DOT_MASK, 20'h0002A);
    add_cfg(CFG_DISPLAY_VALUE, 20'd654321);
    add_cfg(CFG_IDX_SPARE_HI, 20'hFFFFF);
    add_tick(1'b0, 1'b0, 1'b0, 2'd0, '0, '0);
    add_tick(1'b0, 1'b1, 1'b0, 2'd0, '0, '0);
    // value above six digits, zero ticks per second
    add_cfg(CFG_DISPLAY_VALUE, 20'hFFFFF);
    add_cfg(CFG_TICKS_PER_SEC, 20'd0);
    add_cfg(CFG_DURATION, 20'd5);
    add_tick(1'b1, 1'b0, 1'b1, 2'd2, '{16'hFE3F, 1'b0, STOP_NONE},
             '{16'h0000, 1'b1, STOP_DURATION});
    add_tick(1'b1, 1'b1, 1'b1, 2'd2, '{16'hFE3F, 1'b0, STOP_NONE},
             '{16'h0000, 1'b1, STOP_DURATION});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CFG) begin
        write_reg(stim_tab[i].idx, stim_tab[i].data);
      end else begin
        pin_on  = stim_tab[i].pinned;
        pin_cnt = stim_tab[i].n;
        pin_a   = stim_tab[i].a;
        pin_b   = stim_tab[i].b;
        send_tick(stim_tab[i].start, stim_tab[i].quit);
      end
    end

    // random part
    base  = scan_items;
    phase = 0;
    while (scan_items - base < RAND_ITEMS) begin
      drain_results();
      tx_gap_max = pick_gap_max();
      rx_gap_max = pick_gap_max();
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0: val = 20'd0;
          1: val = 20'd999999;
          2: val = 20'hFFFFF;
          default: val = 20'($urandom_range(0, 20'hFFFFF));
        endcase
        write_reg(CFG_DISPLAY_VALUE, val);
      end
      if ($urandom_range(0, 1)) write_reg(CFG_DOT_MASK, 20'($urandom_range(0, 20'hFFFFF)));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0: val[15:0] = 16'd0;
          1: val[15:0] = 16'hFFFF;
          default: val[15:0] = 16'($urandom_range(0, 4));
        endcase
        val[19:16] = 4'($urandom_range(0, 15));
        write_reg(CFG_DURATION, val);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 6))
          0: val[15:0] = 16'd1;
          1: val[15:0] = 16'hFFFF;
          2: val[15:0] = 16'd0;
          default: val[15:0] = 16'($urandom_range(1, 6));
        endcase
        val[19:16] = 4'($urandom_range(0, 15));
        write_reg(CFG_TICKS_PER_SEC, val);
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(3'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                  20'($urandom_range(0, 20'hFFFFF)));

      if (phase == 2) begin
        // output held off for a long stretch while ticks keep coming
        write_reg(CFG_DURATION, 20'hFFFFF);
        write_reg(CFG_TICKS_PER_SEC, 20'hFFFFF);
        tx_gap_max     = 0;
        rx_hold_cycles = HOLD_LONG;
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        repeat (60) send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'($urandom_range(0, 1)));
        run_len = $urandom_range(1, 40);
        send_tick(1'b1, 1'b0);
        repeat (run_len)
          send_tick(1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 24) == 0));
      end
      phase++;
    end

    drain_results();
    repeat (16) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_seven_segment_scan_driver passed");
    end else begin
      $display("tb_seven_segment_scan_driver failed");
    end
    $finish;
  end

endmodule
